FILE: sv/fresnel_dielectric_reflectance_core_macros.svh
// Assertion macros for the Fresnel reflectance core.
// Used by the core's top level; needs no other file.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_CORE_MACROS_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_CORE_MACROS_SVH

// Check that a condition implies a consequence on every clock edge out of reset.
`define FDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdr: implication check failed");

// Check that a condition holds on every clock edge out of reset.
`define FDR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fdr: invariant check failed");

`endif

FILE: sv/fdr_pkg.sv
// Shared widths, constants and sideband types of the Fresnel reflectance core.
// Depends on nothing; imported by every module of the core.
package fdr_pkg;

    localparam int CompW   = 16;   // vector component, signed Q1.14
    localparam int IdxW    = 16;   // refractive index, unsigned Q2.14
    localparam int ReflW   = 17;   // reflectance, unsigned Q1.16
    localparam int CosW    = 29;   // cosine or sine in Q28, up to 1.0
    localparam int RadW    = 57;   // square root radicand, up to 2^56
    localparam int StW     = 28;   // sin_t quotient, below 1.0
    localparam int ProdW   = 45;   // index times Q28 value
    localparam int AmpW    = 30;   // index-cosine product in Q28
    localparam int DenW    = 31;   // ratio denominator
    localparam int NumW    = 60;   // ratio numerator, diff << 30
    localparam int QuoW    = 31;   // ratio magnitude in Q30, up to 1.0
    localparam int SqW     = 62;   // squared ratio plus rounding
    localparam int DotW    = 34;   // sum of three component products
    localparam int PipeLat = 129;  // accept to strobe, in cycles

    localparam logic [ReflW-1:0]       FullRefl  = 17'd65536;
    localparam logic [RadW-1:0]        RadOne    = 57'd1 << 56;
    localparam logic signed [DotW-1:0] DotOne    = 34'sd268435456;
    localparam logic [QuoW-1:0]        RatioOne  = 31'd1 << 30;
    localparam logic [SqW-1:0]         RoundHalf = 62'd1 << 44;

    // Indices, cosine and total internal reflection flag carried beside the square root and divide units.
    typedef struct packed {
        logic            tir;
        logic [IdxW-1:0] n1;
        logic [IdxW-1:0] n2;
        logic [CosW-1:0] c;
    } t_hit;

    // Flags carried beside the parallel ratio divider.
    typedef struct packed {
        logic tir;
        logic den0;
    } t_rat;

endpackage

FILE: sv/fdr_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on fdr_pkg for default widths.
module fdr_sqrt_pipe import fdr_pkg::*; #(
    parameter int IW = RadW,
    parameter int SW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [IW-1:0]           i_rad,
    input  logic [SW-1:0]           i_side,
    output logic                    o_valid,
    output logic [(IW+1)/2-1:0]     o_root,
    output logic [SW-1:0]           o_side
);

    localparam int RW = (IW + 1) / 2;
    localparam int XW = 2 * RW;
    localparam int MW = RW + 2;

    logic [RW:0]    stg_v;
    logic [XW-1:0]  stg_x    [RW+1];
    logic [RW-1:0]  stg_root [RW+1];
    logic [MW-1:0]  stg_rem  [RW+1];
    logic [SW-1:0]  stg_side [RW+1];

    // Feed the first stage
    assign stg_v[0]    = i_valid;
    assign stg_x[0]    = XW'(i_rad);
    assign stg_root[0] = '0;
    assign stg_rem[0]  = '0;
    assign stg_side[0] = i_side;

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic [MW-1:0] n_shift;
        logic [MW-1:0] n_trial;
        logic          n_take;
        logic          r_v;
        logic [XW-1:0] r_x;
        logic [RW-1:0] r_root;
        logic [MW-1:0] r_rem;
        logic [SW-1:0] r_side;

        // Bring down two radicand bits and try the next root bit
        always_comb begin
            n_shift = {stg_rem[g][MW-3:0], stg_x[g][XW-1 -: 2]};
            n_trial = {stg_root[g], 2'b01};
            n_take  = (n_shift >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= stg_v[g];
            end
        end

        // Advance the word
        always_ff @(posedge i_clk) begin
            r_x    <= {stg_x[g][XW-3:0], 2'b00};
            r_rem  <= n_take ? (n_shift - n_trial) : n_shift;
            r_root <= {stg_root[g][RW-2:0], n_take};
            r_side <= stg_side[g];
        end

        assign stg_v[g+1]    = r_v;
        assign stg_x[g+1]    = r_x;
        assign stg_root[g+1] = r_root;
        assign stg_rem[g+1]  = r_rem;
        assign stg_side[g+1] = r_side;
    end

    assign o_valid = stg_v[RW];
    assign o_root  = stg_root[RW];
    assign o_side  = stg_side[RW];

endmodule

FILE: sv/fdr_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fdr_pkg for default widths; quotient must fit in QW bits.
module fdr_div_pipe import fdr_pkg::*; #(
    parameter int NW = NumW,
    parameter int DW = DenW,
    parameter int QW = QuoW,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int MW = DW + 1;

    logic [QW:0]    stg_v;
    logic [MW-1:0]  stg_rem  [QW+1];
    logic [QW-1:0]  stg_lo   [QW+1];
    logic [QW-1:0]  stg_q    [QW+1];
    logic [DW-1:0]  stg_den  [QW+1];
    logic [SW-1:0]  stg_side [QW+1];

    // Upper numerator bits start as the partial remainder
    assign stg_v[0]    = i_valid;
    assign stg_rem[0]  = MW'(i_num[NW-1:QW]);
    assign stg_lo[0]   = i_num[QW-1:0];
    assign stg_q[0]    = '0;
    assign stg_den[0]  = i_den;
    assign stg_side[0] = i_side;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [MW-1:0] n_shift;
        logic          n_take;
        logic          r_v;
        logic [MW-1:0] r_rem;
        logic [QW-1:0] r_lo;
        logic [QW-1:0] r_q;
        logic [DW-1:0] r_den;
        logic [SW-1:0] r_side;

        // Shift in one numerator bit and compare against the divisor
        always_comb begin
            n_shift = {stg_rem[g][MW-2:0], stg_lo[g][QW-1]};
            n_take  = (n_shift >= {1'b0, stg_den[g]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else begin
                r_v <= stg_v[g];
            end
        end

        // Advance the word
        always_ff @(posedge i_clk) begin
            r_rem  <= n_take ? (n_shift - {1'b0, stg_den[g]}) : n_shift;
            r_lo   <= {stg_lo[g][QW-2:0], 1'b0};
            r_q    <= {stg_q[g][QW-2:0], n_take};
            r_den  <= stg_den[g];
            r_side <= stg_side[g];
        end

        assign stg_v[g+1]    = r_v;
        assign stg_rem[g+1]  = r_rem;
        assign stg_lo[g+1]   = r_lo;
        assign stg_q[g+1]    = r_q;
        assign stg_den[g+1]  = r_den;
        assign stg_side[g+1] = r_side;
    end

    assign o_valid = stg_v[QW];
    assign o_quo   = stg_q[QW];
    assign o_side  = stg_side[QW];

endmodule

FILE: sv/fresnel_dielectric_reflectance_core.sv
// Unpolarized Fresnel reflectance core: takes one hit (normal, direction, two
// indices) per clock and strobes one reflectance word on o_valid for each
// accepted start; busy stays low, so a word may be started every cycle and
// results are never held off. The latency is set by the bit-per-stage units:
// two 29-stage square roots, a 28-stage sin_t divider and two parallel
// 31-stage ratio dividers, plus 12 arithmetic stages around them.
// Depends on fdr_pkg, fdr_sqrt_pipe, fdr_div_pipe and the macros header.
`include "fresnel_dielectric_reflectance_core_macros.svh"

module fresnel_dielectric_reflectance_core import fdr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [CompW-1:0] i_normal_x,
    input  logic signed [CompW-1:0] i_normal_y,
    input  logic signed [CompW-1:0] i_normal_z,
    input  logic signed [CompW-1:0] i_dir_x,
    input  logic signed [CompW-1:0] i_dir_y,
    input  logic signed [CompW-1:0] i_dir_z,
    input  logic [IdxW-1:0]         i_index_front,
    input  logic [IdxW-1:0]         i_index_back,
    output logic                    o_valid,
    output logic [ReflW-1:0]        o_reflectance,
    output logic                    o_total_internal
);

    logic w_acc;

    // The pipeline never stalls
    assign busy  = 1'b0;
    assign w_acc = start & ~busy;

    // Stage A: component products
    logic                    r_a_v;
    logic signed [31:0]      r_a_px, r_a_py, r_a_pz;
    logic [IdxW-1:0]         r_a_n1, r_a_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_px <= 32'(i_normal_x) * 32'(i_dir_x);
        r_a_py <= 32'(i_normal_y) * 32'(i_dir_y);
        r_a_pz <= 32'(i_normal_z) * 32'(i_dir_z);
        r_a_n1 <= i_index_front;
        r_a_n2 <= i_index_back;
    end

    // Stage B: dot product, clamp, swap on back-facing hits
    logic signed [DotW-1:0] n_dot, n_clamp, n_neg;
    logic [IdxW-1:0]        n_n1z, n_n2z;
    logic                   r_b_v;
    logic [CosW-1:0]        r_b_c;
    logic [IdxW-1:0]        r_b_n1, r_b_n2;

    always_comb begin
        n_dot = DotW'(r_a_px) + DotW'(r_a_py) + DotW'(r_a_pz);
        if (n_dot > DotOne) begin
            n_clamp = DotOne;
        end else if (n_dot < -DotOne) begin
            n_clamp = -DotOne;
        end else begin
            n_clamp = n_dot;
        end
        n_neg = -n_clamp;
        n_n1z = (r_a_n1 == '0) ? IdxW'(1) : r_a_n1;
        n_n2z = (r_a_n2 == '0) ? IdxW'(1) : r_a_n2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_clamp <= 0) begin
            r_b_c  <= n_neg[CosW-1:0];
            r_b_n1 <= n_n2z;
            r_b_n2 <= n_n1z;
        end else begin
            r_b_c  <= n_clamp[CosW-1:0];
            r_b_n1 <= n_n1z;
            r_b_n2 <= n_n2z;
        end
    end

    // Stage C: square the cosine
    logic [2*CosW-1:0] n_csq;
    logic              r_c_v;
    logic [RadW-1:0]   r_c_csq;
    t_hit              r_c_hit;

    assign n_csq = {{CosW{1'b0}}, r_b_c} * {{CosW{1'b0}}, r_b_c};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_csq     <= n_csq[RadW-1:0];
        r_c_hit.tir <= 1'b0;
        r_c_hit.n1  <= r_b_n1;
        r_c_hit.n2  <= r_b_n2;
        r_c_hit.c   <= r_b_c;
    end

    // Stage D: radicand for sin_i
    logic            r_d_v;
    logic [RadW-1:0] r_d_rad;
    t_hit            r_d_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_rad <= RadOne - r_c_csq;
        r_d_hit <= r_c_hit;
    end

    // sin_i
    logic            w_si_v;
    logic [CosW-1:0] w_si;
    t_hit            w_si_hit;

    fdr_sqrt_pipe #(
        .IW (RadW),
        .SW ($bits(t_hit))
    ) u_sqrt_si (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_v),
        .i_rad   (r_d_rad),
        .i_side  (r_d_hit),
        .o_valid (w_si_v),
        .o_root  (w_si),
        .o_side  (w_si_hit)
    );

    // Stage E: n1 * sin_i
    logic [ProdW-1:0] n_p;
    logic             r_e_v;
    logic [ProdW-1:0] r_e_p;
    t_hit             r_e_hit;

    assign n_p = {{(ProdW-IdxW){1'b0}}, w_si_hit.n1} * {{(ProdW-CosW){1'b0}}, w_si};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= w_si_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_p   <= n_p;
        r_e_hit <= w_si_hit;
    end

    // Stage F: exact total internal reflection test
    logic             r_f_v;
    logic [ProdW-1:0] r_f_p;
    t_hit             r_f_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_p       <= r_e_p;
        r_f_hit.tir <= (r_e_p >= {1'b0, r_e_hit.n2, {StW{1'b0}}});
        r_f_hit.n1  <= r_e_hit.n1;
        r_f_hit.n2  <= r_e_hit.n2;
        r_f_hit.c   <= r_e_hit.c;
    end

    // sin_t = n1 * sin_i / n2
    logic           w_st_v;
    logic [StW-1:0] w_st;
    t_hit           w_st_hit;

    fdr_div_pipe #(
        .NW (ProdW),
        .DW (IdxW),
        .QW (StW),
        .SW ($bits(t_hit))
    ) u_div_st (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_num   (r_f_p),
        .i_den   (r_f_hit.n2),
        .i_side  (r_f_hit),
        .o_valid (w_st_v),
        .o_quo   (w_st),
        .o_side  (w_st_hit)
    );

    // Stage G: square sin_t
    logic [2*StW-1:0] n_st2;
    logic             r_g_v;
    logic [2*StW-1:0] r_g_st2;
    t_hit             r_g_hit;

    assign n_st2 = {{StW{1'b0}}, w_st} * {{StW{1'b0}}, w_st};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= w_st_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_st2 <= n_st2;
        r_g_hit <= w_st_hit;
    end

    // Stage H: radicand for cos_t
    logic            r_h_v;
    logic [RadW-1:0] r_h_rad;
    t_hit            r_h_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_rad <= RadOne - RadW'(r_g_st2);
        r_h_hit <= r_g_hit;
    end

    // cos_t
    logic            w_ct_v;
    logic [CosW-1:0] w_ct;
    t_hit            w_ct_hit;

    fdr_sqrt_pipe #(
        .IW (RadW),
        .SW ($bits(t_hit))
    ) u_sqrt_ct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_v),
        .i_rad   (r_h_rad),
        .i_side  (r_h_hit),
        .o_valid (w_ct_v),
        .o_root  (w_ct),
        .o_side  (w_ct_hit)
    );

    // Stage I: index-cosine products, truncated to Q28
    logic [ProdW-1:0] n_ap, n_bp, n_as, n_bs;
    logic             r_i_v;
    logic             r_i_tir;
    logic [AmpW-1:0]  r_i_ap, r_i_bp, r_i_as, r_i_bs;

    always_comb begin
        n_ap = {{(ProdW-IdxW){1'b0}}, w_ct_hit.n2} * {{(ProdW-CosW){1'b0}}, w_ct_hit.c};
        n_bp = {{(ProdW-IdxW){1'b0}}, w_ct_hit.n1} * {{(ProdW-CosW){1'b0}}, w_ct};
        n_as = {{(ProdW-IdxW){1'b0}}, w_ct_hit.n1} * {{(ProdW-CosW){1'b0}}, w_ct_hit.c};
        n_bs = {{(ProdW-IdxW){1'b0}}, w_ct_hit.n2} * {{(ProdW-CosW){1'b0}}, w_ct};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else begin
            r_i_v <= w_ct_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i_tir <= w_ct_hit.tir;
        r_i_ap  <= n_ap[AmpW+13:14];
        r_i_bp  <= n_bp[AmpW+13:14];
        r_i_as  <= n_as[AmpW+13:14];
        r_i_bs  <= n_bs[AmpW+13:14];
    end

    // Stage J: ratio numerators and denominators
    logic [DenW-1:0] n_den_p, n_den_s;
    logic [AmpW-1:0] n_dif_p, n_dif_s;
    logic            r_j_v;
    logic [NumW-1:0] r_j_num_p, r_j_num_s;
    logic [DenW-1:0] r_j_den_p, r_j_den_s;
    t_rat            r_j_rat;
    logic            r_j_den0_s;

    always_comb begin
        n_den_p = DenW'(r_i_ap) + DenW'(r_i_bp);
        n_den_s = DenW'(r_i_as) + DenW'(r_i_bs);
        n_dif_p = (r_i_ap >= r_i_bp) ? (r_i_ap - r_i_bp) : (r_i_bp - r_i_ap);
        n_dif_s = (r_i_as >= r_i_bs) ? (r_i_as - r_i_bs) : (r_i_bs - r_i_as);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v <= 1'b0;
        end else begin
            r_j_v <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j_num_p    <= {n_dif_p, {AmpW{1'b0}}};
        r_j_num_s    <= {n_dif_s, {AmpW{1'b0}}};
        r_j_den_p    <= n_den_p;
        r_j_den_s    <= n_den_s;
        r_j_rat.tir  <= r_i_tir;
        r_j_rat.den0 <= (n_den_p == '0);
        r_j_den0_s   <= (n_den_s == '0);
    end

    // Ratio magnitudes, two lanes side by side
    logic            w_rp_v, w_rs_v;
    logic [QuoW-1:0] w_rp, w_rs;
    t_rat            w_rp_rat;
    logic            w_rs_den0;

    fdr_div_pipe #(
        .NW (NumW),
        .DW (DenW),
        .QW (QuoW),
        .SW ($bits(t_rat))
    ) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_j_v),
        .i_num   (r_j_num_p),
        .i_den   (r_j_den_p),
        .i_side  (r_j_rat),
        .o_valid (w_rp_v),
        .o_quo   (w_rp),
        .o_side  (w_rp_rat)
    );

    fdr_div_pipe #(
        .NW (NumW),
        .DW (DenW),
        .QW (QuoW),
        .SW (1)
    ) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_j_v),
        .i_num   (r_j_num_s),
        .i_den   (r_j_den_s),
        .i_side  (r_j_den0_s),
        .o_valid (w_rs_v),
        .o_quo   (w_rs),
        .o_side  (w_rs_den0)
    );

    // Stage K: square the ratios
    logic [QuoW-1:0] n_rp, n_rs;
    logic            r_k_v;
    logic            r_k_tir;
    logic [SqW-1:0]  r_k_rp2, r_k_rs2;

    always_comb begin
        n_rp = w_rp_rat.den0 ? RatioOne : w_rp;
        n_rs = w_rs_den0 ? RatioOne : w_rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_v <= 1'b0;
        end else begin
            r_k_v <= w_rp_v & w_rs_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_tir <= w_rp_rat.tir;
        r_k_rp2 <= {{QuoW{1'b0}}, n_rp} * {{QuoW{1'b0}}, n_rp};
        r_k_rs2 <= {{QuoW{1'b0}}, n_rs} * {{QuoW{1'b0}}, n_rs};
    end

    // Stage L: halve, round to Q16, saturate; full reflectance on total internal reflection
    logic [SqW-1:0]   n_sum;
    logic [ReflW-1:0] n_refl;
    logic             r_o_v;
    logic [ReflW-1:0] r_o_refl;
    logic             r_o_tir;

    always_comb begin
        n_sum  = r_k_rp2 + r_k_rs2 + RoundHalf;
        n_refl = n_sum[SqW-1:SqW-ReflW];
        if (r_k_tir || (n_refl > FullRefl)) begin
            n_refl = FullRefl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else begin
            r_o_v <= r_k_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_refl <= n_refl;
        r_o_tir  <= r_k_tir;
    end

    assign o_valid          = r_o_v;
    assign o_reflectance    = r_o_refl;
    assign o_total_internal = r_o_tir;

    // Checks on latency and result range
    `FDR_ASSERT_IMP(a_acc_lat, i_clk, i_rst_n, w_acc, ##PipeLat o_valid)
    `FDR_ASSERT_IMP(a_out_src, i_clk, i_rst_n, o_valid, $past(w_acc, PipeLat))
    `FDR_ASSERT_IMP(a_tir_full, i_clk, i_rst_n, o_valid && o_total_internal, o_reflectance == FullRefl)
    `FDR_ASSERT_ALWAYS(a_refl_sat, i_clk, i_rst_n, !o_valid || (o_reflectance <= FullRefl))

endmodule

FILE: bench/fresnel_dielectric_reflectance_core_tb.sv
// Self-checking bench for the Fresnel reflectance core: directed and random hits,
// a built-in reflectance predictor and an in-order check of every result word.
// Depends on fdr_pkg and fresnel_dielectric_reflectance_core.
`timescale 1ns / 100ps

module fresnel_dielectric_reflectance_core_tb;
    import fdr_pkg::*;

    localparam int IdleLimit = 2000;
    localparam longint unsigned Q28 = 64'd1 << 28;
    localparam longint unsigned Q56 = 64'd1 << 56;
    localparam longint unsigned Q30 = 64'd1 << 30;

    typedef struct {
        logic signed [CompW-1:0] nx, ny, nz, dx, dy, dz;
        logic [IdxW-1:0]         n_front, n_back;
        int                      gap;
        bit                      drain;
    } t_hit_word;

    typedef struct {
        logic [ReflW-1:0] refl;
        logic             tir;
    } t_refl_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [CompW-1:0] i_normal_x = '0, i_normal_y = '0, i_normal_z = '0;
    logic signed [CompW-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [IdxW-1:0]         i_index_front = '0, i_index_back = '0;
    logic                    o_valid;
    logic [ReflW-1:0]        o_reflectance;
    logic                    o_total_internal;

    t_hit_word  hit_queue[$];
    t_refl_word refl_expected[$];
    int         errors = 0;
    int         idle_cycles = 0;

    fresnel_dielectric_reflectance_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_dir_x          (i_dir_x),
        .i_dir_y          (i_dir_y),
        .i_dir_z          (i_dir_z),
        .i_index_front    (i_index_front),
        .i_index_back     (i_index_back),
        .o_valid          (o_valid),
        .o_reflectance    (o_reflectance),
        .o_total_internal (o_total_internal)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Magnitude of (a - b) / (a + b) in Q30
    function automatic longint unsigned amp_ratio(longint unsigned a, longint unsigned b);
        longint unsigned diff;
        diff = (a >= b) ? a - b : b - a;
        if (a + b == 0) return Q30;
        return (diff << 30) / (a + b);
    endfunction

    function automatic t_refl_word predict_reflectance(t_hit_word h);
        t_refl_word      r;
        longint          dot;
        longint unsigned n1, n2, tmp, c, si, st, ct, rp, rs, sum;
        dot = longint'(h.nx) * longint'(h.dx) + longint'(h.ny) * longint'(h.dy)
            + longint'(h.nz) * longint'(h.dz);
        n1 = (h.n_front == 0) ? 64'd1 : 64'(h.n_front);
        n2 = (h.n_back == 0) ? 64'd1 : 64'(h.n_back);
        if (dot > longint'(Q28)) dot = Q28;
        if (dot < -longint'(Q28)) dot = -longint'(Q28);
        // Hit from the far side: swap indices, take the magnitude
        if (dot <= 0) begin
            tmp = n1;
            n1 = n2;
            n2 = tmp;
            c = -dot;
        end else begin
            c = dot;
        end
        si = int_sqrt(Q56 - c * c);
        if (n1 * si >= (n2 << 28)) begin
            r.refl = FullRefl;
            r.tir = 1'b1;
            return r;
        end
        st = (n1 * si) / n2;
        ct = int_sqrt(Q56 - st * st);
        rp = amp_ratio((n2 * c) >> 14, (n1 * ct) >> 14);
        rs = amp_ratio((n1 * c) >> 14, (n2 * ct) >> 14);
        sum = (rp * rp + rs * rs + (64'd1 << 44)) >> 45;
        r.refl = (sum > 65536) ? FullRefl : sum[ReflW-1:0];
        r.tir = 1'b0;
        return r;
    endfunction

    // Drive words from the queue, honoring gaps and drain points
    always @(posedge i_clk) begin
        logic next_start;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            next_start = 1'b0;
            if (start && !busy) begin
                t_hit_word cur;
                cur.nx = i_normal_x; cur.ny = i_normal_y; cur.nz = i_normal_z;
                cur.dx = i_dir_x;    cur.dy = i_dir_y;    cur.dz = i_dir_z;
                cur.n_front = i_index_front;
                cur.n_back = i_index_back;
                refl_expected.push_back(predict_reflectance(cur));
            end
            if (start && busy) begin
                next_start = 1'b1;
            end else if (hit_queue.size() != 0) begin
                if (hit_queue[0].gap > 0) begin
                    hit_queue[0].gap--;
                end else if (hit_queue[0].drain && (refl_expected.size() != 0)) begin
                    // hold until every result is back
                end else begin
                    t_hit_word w;
                    w = hit_queue.pop_front();
                    i_normal_x <= w.nx; i_normal_y <= w.ny; i_normal_z <= w.nz;
                    i_dir_x <= w.dx;    i_dir_y <= w.dy;    i_dir_z <= w.dz;
                    i_index_front <= w.n_front;
                    i_index_back <= w.n_back;
                    next_start = 1'b1;
                end
            end
            start <= next_start;
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (refl_expected.size() == 0) begin
                $display("%0t: unexpected word refl=%0d tir=%0b", $time,
                         o_reflectance, o_total_internal);
                errors++;
            end else begin
                t_refl_word e;
                e = refl_expected.pop_front();
                if (o_reflectance !== e.refl) begin
                    $display("%0t: reflectance expected %0d actual %0d", $time,
                             e.refl, o_reflectance);
                    errors++;
                end
                if (o_total_internal !== e.tir) begin
                    $display("%0t: total_internal expected %0b actual %0b", $time,
                             e.tir, o_total_internal);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no traffic on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("fresnel_dielectric_reflectance_core_tb NOT OK");
                $finish;
            end
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [CompW-1:0] rand_comp();
        return CompW'($signed(32'($urandom_range(0, 32768)) - 32'sd16384));
    endfunction

    // Random near-unit vector in Q1.14
    task automatic rand_unit(output logic signed [CompW-1:0] v[3]);
        longint a, b, c;
        int     k;
        a = longint'($urandom_range(0, 23170)) - 11585;
        b = longint'($urandom_range(0, 23170)) - 11585;
        c = int_sqrt(longint'(Q28) - a * a - b * b);
        if ($urandom_range(0, 1)) c = -c;
        k = $urandom_range(0, 2);
        v[k] = CompW'(c);
        v[(k + 1) % 3] = CompW'(a);
        v[(k + 2) % 3] = CompW'(b);
    endtask

    task automatic add_hit(int nx, int ny, int nz, int dx, int dy, int dz,
                           int nf, int nb, int gap, bit drain);
        t_hit_word w;
        w.nx = CompW'(nx); w.ny = CompW'(ny); w.nz = CompW'(nz);
        w.dx = CompW'(dx); w.dy = CompW'(dy); w.dz = CompW'(dz);
        w.n_front = IdxW'(nf);
        w.n_back = IdxW'(nb);
        w.gap = gap;
        w.drain = drain;
        hit_queue.push_back(w);
    endtask

    initial begin
        logic signed [CompW-1:0] nv[3], dv[3];
        int  nf, nb;
        bit  burst;
        // Directed: normal incidence, reversed side, grazing, full reflection,
        // index extremes, clamped non-unit vectors, equal indices
        add_hit(0, 0, 16384, 0, 0, 16384, 16384, 24576, 0, 0);
        add_hit(0, 0, 16384, 0, 0, -16384, 16384, 24576, 0, 0);
        add_hit(0, 0, 16384, 16384, 0, 0, 16384, 24576, 1, 0);
        add_hit(0, 0, 16384, 16384, 0, 0, 24576, 16384, 0, 0);
        add_hit(0, 0, 16384, 14189, 0, 8192, 65535, 16384, 0, 0);
        add_hit(0, 0, 16384, 14189, 0, -8192, 16384, 65535, 2, 0);
        add_hit(0, 0, 16384, 11585, 0, 11585, 65535, 65535, 0, 0);
        add_hit(16384, 16384, 16384, 16384, 16384, 16384, 16384, 40000, 0, 0);
        add_hit(-16384, -16384, -16384, -16384, -16384, -16384, 30000, 20000, 0, 0);
        add_hit(-16384, -16384, -16384, 16384, 16384, 16384, 30000, 20000, 0, 0);
        add_hit(0, 0, 16384, 16383, 181, 0, 24576, 16384, 0, 0);
        add_hit(0, 0, 16384, 16383, 181, 0, 16384, 24576, 0, 0);
        add_hit(0, 11585, 11585, 0, 0, 16384, 21790, 16384, 5, 0);
        add_hit(0, 0, 16384, 0, 0, 16384, 65535, 16384, 0, 1);
        // Random: mostly unit vectors, some raw component values
        for (int i = 0; i < 736; i++) begin
            if (i % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                rand_unit(nv);
                rand_unit(dv);
            end else begin
                foreach (nv[k]) nv[k] = rand_comp();
                foreach (dv[k]) dv[k] = rand_comp();
            end
            nf = $urandom_range(16384, 65535);
            nb = ($urandom_range(0, 9) == 0) ? nf : $urandom_range(16384, 65535);
            add_hit(nv[0], nv[1], nv[2], dv[0], dv[1], dv[2], nf, nb,
                    pick_gap(burst), (i == 300) || (i == 600));
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (hit_queue.size() != 0 || start) @(posedge i_clk);
        while (refl_expected.size() != 0) @(posedge i_clk);
        repeat (PipeLat + 20) @(posedge i_clk);
        if (errors == 0 && refl_expected.size() == 0) begin
            $display("fresnel_dielectric_reflectance_core_tb OK");
        end else begin
            $display("fresnel_dielectric_reflectance_core_tb NOT OK");
        end
        $finish;
    end

endmodule
